FILE: hw/rtl/zigzag_scan_order_assert.svh
// Assertion macros shared by the zigzag scan order checker.
`ifndef ZIGZAG_SCAN_ORDER_ASSERT_SVH
`define ZIGZAG_SCAN_ORDER_ASSERT_SVH

// Same-cycle implication, disabled while r is high.
`define ZZSO_ASSERT_NOW(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("zzso check failed");

// Next-cycle implication, disabled while r is high.
`define ZZSO_ASSERT_NEXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("zzso check failed");

`endif

FILE: hw/rtl/zzso_pkg.sv
// Types and constants for the zigzag scan order generator.
`timescale 1ns / 1ps
package zzso_pkg;

  localparam int IDX_W   = 6;   // row and column index width
  localparam int DIM_W   = 7;   // rows and cols register width
  localparam int COUNT_W = 13;  // order number width
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam int INDEX_LIMIT = 64;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DOWN = 2'd2;

  localparam logic [DIM_W-1:0] ROWS_RESET = 7'd8;
  localparam logic [DIM_W-1:0] COLS_RESET = 7'd8;

  // Effective configuration handed to the step logic.
  typedef struct packed {
    logic [DIM_W-1:0]   rows;
    logic [DIM_W-1:0]   cols;
    logic [COUNT_W-1:0] total;
    logic               first_down;
  } cfg_t;

  // Scan position and progress.
  typedef struct packed {
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic               up_right;
    logic [COUNT_W-1:0] count;
    logic               active;
  } scan_t;

endpackage

FILE: hw/rtl/zigzag_scan_order.sv
// Top level of the zigzag scan order generator.
`timescale 1ns / 1ps
//
//  channel  dir  beat contents
//  -------  ---  ---------------------------------------------------------
//  s_*      in   tdata[0] restart (1 restart at (0,0), 0 advance)
//  m_*      out  tdata row[5:0] col[11:6] order[24:12], tlast final cell
//  cfg_*    in   write: index 0 rows, 1 cols, 2 first_step_down
//
//  One beat per cycle while the m_ side takes results; a result passes
//  through the input register, then the result register.
//  The scan state is updated as a beat leaves the input register.
//  rst is synchronous, active high; it clears both stages and the scan
//  state and loads rows = cols = 8, first move right. No clearing pass.
//  A stalled m_ side holds its result; one more input beat is taken into
//  the input register, then s_tready drops until the result is taken.
//
module zigzag_scan_order #(
  parameter int MAX_DIM = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [zzso_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [zzso_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [0] restart, [7:1] zero
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [31:0]                       m_tdata,   // row, col, order, zero
  output logic                              m_tlast    // last cell of scan
);
  import zzso_pkg::*;

  cfg_t  cfg;
  scan_t scan;
  scan_t scan_next;
  logic  emit;
  logic  is_last;

  // input register
  logic in_v;
  logic in_restart;

  // result register
  logic               out_v;
  logic [IDX_W-1:0]   out_row;
  logic [IDX_W-1:0]   out_col;
  logic [COUNT_W-1:0] out_order;
  logic               out_last;

  logic advance;
  logic fire;

  zzso_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  zzso_step u_step (
    .cfg     (cfg),
    .cur     (scan),
    .restart (in_restart),
    .nxt     (scan_next),
    .emit    (emit),
    .last    (is_last)
  );

  // Result register can take a new value when empty or being drained.
  assign advance  = ~out_v | m_tready;
  assign fire     = in_v & advance;
  assign s_tready = ~in_v | advance;

  // Hold the accepted beat until the step logic consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_restart <= s_tdata[0];
    end
  end

  // Advance the scan state once per consumed beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else if (fire) begin
      scan <= scan_next;
    end
  end

  // Drop beats that produce no result (advance while idle).
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance) begin
      out_v <= fire & emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_row   <= scan_next.row;
      out_col   <= scan_next.col;
      out_order <= scan_next.count;
      out_last  <= is_last;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {7'd0, out_order, out_col, out_row};
  assign m_tlast  = out_last;

endmodule

FILE: hw/rtl/zzso_cfg.sv
// Configuration registers with dimension clamping and cell total.
`timescale 1ns / 1ps
module zzso_cfg #(
  parameter int MAX_DIM = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [zzso_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [zzso_pkg::CFG_DATA_W-1:0]   cfg_data,
  output zzso_pkg::cfg_t                    cfg
);
  import zzso_pkg::*;

  localparam int DIM_LIMIT = (MAX_DIM < INDEX_LIMIT) ? MAX_DIM : INDEX_LIMIT;
  localparam logic [DIM_W-1:0] LIM = DIM_W'(DIM_LIMIT);

  logic [DIM_W-1:0] rows;
  logic [DIM_W-1:0] cols;
  logic             first_down;
  logic [DIM_W-1:0] rows_eff;
  logic [DIM_W-1:0] cols_eff;
  logic [2*DIM_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows       <= ROWS_RESET;
      cols       <= COLS_RESET;
      first_down <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS:       rows       <= cfg_data[DIM_W-1:0];
        REG_COLS:       cols       <= cfg_data[DIM_W-1:0];
        REG_FIRST_DOWN: first_down <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp to 1..limit.
  always_comb begin
    rows_eff = (rows == '0) ? DIM_W'(1) : ((rows > LIM) ? LIM : rows);
    cols_eff = (cols == '0) ? DIM_W'(1) : ((cols > LIM) ? LIM : cols);
    prod     = (2*DIM_W)'(rows_eff) * (2*DIM_W)'(cols_eff);
  end

  assign cfg.rows       = rows_eff;
  assign cfg.cols       = cols_eff;
  assign cfg.total      = prod[COUNT_W-1:0];
  assign cfg.first_down = first_down;

endmodule

FILE: hw/rtl/zzso_step.sv
// Next-cell logic of the diagonal scan.
`timescale 1ns / 1ps
module zzso_step (
  input  zzso_pkg::cfg_t   cfg,
  input  zzso_pkg::scan_t  cur,
  input  logic             restart,
  output zzso_pkg::scan_t  nxt,
  output logic             emit,
  output logic             last
);
  import zzso_pkg::*;

  logic [DIM_W-1:0] col_p1;
  logic [DIM_W-1:0] row_p1;

  always_comb begin
    col_p1 = {1'b0, cur.col} + DIM_W'(1);
    row_p1 = {1'b0, cur.row} + DIM_W'(1);
    nxt    = cur;
    emit   = 1'b1;
    if (restart) begin
      nxt.row      = '0;
      nxt.col      = '0;
      nxt.up_right = ~cfg.first_down;
      nxt.count    = COUNT_W'(1);
    end else if (!cur.active) begin
      emit = 1'b0;
    end else begin
      if (cur.up_right) begin
        if (col_p1 >= cfg.cols) begin
          nxt.row      = cur.row + IDX_W'(1);
          nxt.up_right = 1'b0;
        end else if (cur.row == '0) begin
          nxt.col      = cur.col + IDX_W'(1);
          nxt.up_right = 1'b0;
        end else begin
          nxt.row = cur.row - IDX_W'(1);
          nxt.col = cur.col + IDX_W'(1);
        end
      end else begin
        if (row_p1 >= cfg.rows) begin
          nxt.col      = cur.col + IDX_W'(1);
          nxt.up_right = 1'b1;
        end else if (cur.col == '0) begin
          nxt.row      = cur.row + IDX_W'(1);
          nxt.up_right = 1'b1;
        end else begin
          nxt.row = cur.row + IDX_W'(1);
          nxt.col = cur.col - IDX_W'(1);
        end
      end
      nxt.count = cur.count + COUNT_W'(1);
    end
    last = nxt.count >= cfg.total;
    if (emit) begin
      nxt.active = ~last;
    end
  end

endmodule

FILE: hw/rtl/zzso_checker.sv
// Port-level assertions for the zigzag scan order generator, with bind.
`timescale 1ns / 1ps
`include "zigzag_scan_order_assert.svh"
module zzso_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // Hold a stalled result beat.
  `ZZSO_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Reset empties the result register.
  `ZZSO_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid)

  // An empty result stage always takes input.
  `ZZSO_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)

  // The first cell of a scan is the origin.
  `ZZSO_ASSERT_NOW(a_first_is_origin, clk, rst, m_tvalid && (m_tdata[24:12] == 13'd1), (m_tdata[5:0] == 6'd0) && (m_tdata[11:6] == 6'd0))

endmodule

bind zigzag_scan_order zzso_checker u_zzso_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
